### hdl/sqrt_continued_fraction_defines.svh
// Assertion macros shared by the square root continued fraction RTL.
`ifndef SQRT_CONTINUED_FRACTION_DEFINES_SVH
`define SQRT_CONTINUED_FRACTION_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define SCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define SCF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hdl/scf_pkg.sv
// Shared types, microcode table and constants of the continued fraction block.
package scf_pkg;

  localparam int TERM_W = 6;
  localparam int PC_W   = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SQRT,
    OP_SQCHK,
    OP_TEST,
    OP_MUL_DA,
    OP_SUB_M,
    OP_MUL_MM,
    OP_SUB_N,
    OP_EMIT,
    OP_DIV_D,
    OP_DIV_A
  } op_e;

  typedef struct packed {
    op_e op;
    pc_t jump;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  localparam pc_t PC_IDLE = pc_t'(0);
  localparam pc_t PC_TEST = pc_t'(3);

  // Control store: one word per step, jump used by the branching steps.
  function automatic uword_t rom(pc_t pc);
    uword_t w;
    case (pc)
      pc_t'(0):  w = '{op: OP_IDLE,   jump: PC_IDLE};
      pc_t'(1):  w = '{op: OP_SQRT,   jump: PC_IDLE};
      pc_t'(2):  w = '{op: OP_SQCHK,  jump: PC_IDLE};
      pc_t'(3):  w = '{op: OP_TEST,   jump: PC_IDLE};
      pc_t'(4):  w = '{op: OP_MUL_DA, jump: PC_IDLE};
      pc_t'(5):  w = '{op: OP_SUB_M,  jump: PC_IDLE};
      pc_t'(6):  w = '{op: OP_MUL_MM, jump: PC_IDLE};
      pc_t'(7):  w = '{op: OP_SUB_N,  jump: PC_IDLE};
      pc_t'(8):  w = '{op: OP_EMIT,   jump: PC_IDLE};
      pc_t'(9):  w = '{op: OP_DIV_D,  jump: PC_IDLE};
      pc_t'(10): w = '{op: OP_DIV_A,  jump: PC_TEST};
      default:   w = '{op: OP_IDLE,   jump: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/scf_div.sv
// Restoring divider, one quotient bit per cycle.
module scf_div #(
  parameter int NW = 10,
  parameter int DW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DW-1:0]        den_i,
  output scf_pkg::div_sts_t    sts_o,
  output logic [NW-1:0]        quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;

  logic [DW:0]   sh;
  logic          ge;
  logic [DW:0]   diff;

  assign sh   = {rem_q, quo_q[NW-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end else if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

### hdl/sqrt_continued_fraction.sv
// Microcoded continued fraction expansion of sqrt(radicand), one term per output request.
// The first term follows the square root steps. Each further term takes two passes through
// the shared divider plus the sequencer steps; up to MAX_TERMS terms per radicand, held while
// the output stalls. Next radicand taken after the last term; reset (rst_ni low, async) drops
// any pending term.
`include "sqrt_continued_fraction_defines.svh"

module sqrt_continued_fraction #(
  parameter int RADICAND_BITS = 10,
  parameter int MAX_TERMS     = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [RADICAND_BITS-1:0]     radicand_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [scf_pkg::TERM_W-1:0]   term_o,
  output logic                         last_o,
  output logic                         truncated_o
);

  localparam int SQ_IT = (RADICAND_BITS + 1) / 2;
  localparam int NPAD  = 2 * SQ_IT;
  localparam int RW    = SQ_IT + 1;
  localparam int VW    = SQ_IT + 1;
  localparam int PW    = 2 * VW;
  localparam int SCW   = $clog2(SQ_IT + 1);
  localparam int TCW   = $clog2(MAX_TERMS + 1);

  scf_pkg::pc_t     pc_q, pc_d;
  scf_pkg::uword_t  uw;
  scf_pkg::div_sts_t div_sts;

  logic                     out_valid_q;
  logic [scf_pkg::TERM_W-1:0] term_q;
  logic                     last_q;
  logic                     trunc_q;
  logic                     div_wait_q;
  logic [SCW-1:0]           sq_cnt_q;
  logic [TCW-1:0]           term_cnt_q;

  logic [RADICAND_BITS-1:0] n_q;
  logic [NPAD-1:0]          sq_n_q;
  logic [SQ_IT-1:0]         root_q;
  logic [RW-1:0]            rem_q;
  logic [VW-1:0]            m_q;
  logic [VW-1:0]            d_q;
  logic [VW-1:0]            a_q;
  logic [VW-1:0]            nm_q;
  logic [PW-1:0]            prod_q;
  logic [RADICAND_BITS-1:0] num_q;

  logic [RW+1:0]            rem_sh;
  logic [RW+1:0]            trial;
  logic                     sq_ge;
  logic [RW+1:0]            rem_sub;
  logic [VW-1:0]            a0;
  logic [PW-1:0]            nd_full;
  logic                     slot_free;
  logic                     closes;
  logic                     at_cap;
  logic                     emit;
  logic                     emit_last;
  logic                     emit_trunc;
  logic                     div_start;
  logic                     div_op;
  logic [RADICAND_BITS-1:0] div_num;
  logic [RADICAND_BITS-1:0] div_quo;

  assign uw = scf_pkg::rom(pc_q);

  // Square root datapath: bring down two radicand bits per step.
  assign rem_sh  = {rem_q, sq_n_q[NPAD-1 -: 2]};
  assign trial   = (RW + 2)'({root_q, 2'b01});
  assign sq_ge   = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  assign a0        = VW'(root_q);
  assign nd_full   = PW'(n_q) - prod_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign closes    = (term_cnt_q != '0) && (a_q == VW'({root_q, 1'b0}));
  assign at_cap    = term_cnt_q >= TCW'(MAX_TERMS - 1);
  assign div_num   = (uw.op == scf_pkg::OP_DIV_A) ? RADICAND_BITS'(a0 + m_q) : num_q;
  assign div_op    = (uw.op == scf_pkg::OP_DIV_D) || (uw.op == scf_pkg::OP_DIV_A);

  always_comb begin
    pc_d       = pc_q;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_trunc = 1'b0;
    div_start  = 1'b0;
    case (uw.op)
      scf_pkg::OP_IDLE: begin
        if (in_valid_i) pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
      end
      scf_pkg::OP_SQRT: begin
        if (sq_cnt_q == SCW'(1)) pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
      end
      scf_pkg::OP_SQCHK: begin
        if (rem_q == '0) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            pc_d      = uw.jump;
          end
        end else begin
          pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
        end
      end
      scf_pkg::OP_TEST: begin
        if (closes || at_cap) begin
          if (slot_free) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_trunc = !closes;
            pc_d       = uw.jump;
          end
        end else begin
          pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
        end
      end
      scf_pkg::OP_MUL_DA, scf_pkg::OP_SUB_M, scf_pkg::OP_MUL_MM, scf_pkg::OP_SUB_N: begin
        pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
      end
      scf_pkg::OP_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          // a zero denominator ends the expansion early
          if (num_q == '0 || d_q == '0) begin
            emit_last  = 1'b1;
            emit_trunc = 1'b1;
            pc_d       = uw.jump;
          end else begin
            pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
          end
        end
      end
      scf_pkg::OP_DIV_D: begin
        div_start = !div_wait_q;
        if (div_sts.done) pc_d = scf_pkg::pc_t'(pc_q + 1'b1);
      end
      scf_pkg::OP_DIV_A: begin
        div_start = !div_wait_q;
        if (div_sts.done) pc_d = uw.jump;
      end
      default: begin
        pc_d = scf_pkg::PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= scf_pkg::PC_IDLE;
      out_valid_q <= 1'b0;
      div_wait_q  <= 1'b0;
      sq_cnt_q    <= '0;
      term_cnt_q  <= '0;
    end else begin
      pc_q <= pc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_start) begin
        div_wait_q <= 1'b1;
      end else if (div_sts.done) begin
        div_wait_q <= 1'b0;
      end
      if (uw.op == scf_pkg::OP_IDLE) begin
        sq_cnt_q <= SCW'(SQ_IT);
      end else if (uw.op == scf_pkg::OP_SQRT) begin
        sq_cnt_q <= sq_cnt_q - SCW'(1);
      end
      if (uw.op == scf_pkg::OP_SQCHK) begin
        term_cnt_q <= '0;
      end else if (emit && !emit_last && uw.op == scf_pkg::OP_EMIT) begin
        term_cnt_q <= term_cnt_q + TCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      term_q  <= (uw.op == scf_pkg::OP_SQCHK) ? scf_pkg::TERM_W'(root_q)
                                              : scf_pkg::TERM_W'(a_q);
      last_q  <= emit_last;
      trunc_q <= emit_trunc;
    end
    case (uw.op)
      scf_pkg::OP_IDLE: begin
        n_q    <= radicand_i;
        sq_n_q <= NPAD'(radicand_i);
        root_q <= '0;
        rem_q  <= '0;
      end
      scf_pkg::OP_SQRT: begin
        sq_n_q <= sq_n_q << 2;
        rem_q  <= sq_ge ? RW'(rem_sub) : RW'(rem_sh);
        root_q <= SQ_IT'({root_q, sq_ge});
      end
      scf_pkg::OP_SQCHK: begin
        m_q <= '0;
        d_q <= VW'(1);
        a_q <= a0;
      end
      scf_pkg::OP_MUL_DA: prod_q <= PW'(d_q) * PW'(a_q);
      scf_pkg::OP_SUB_M:  nm_q   <= VW'(prod_q - PW'(m_q));
      scf_pkg::OP_MUL_MM: prod_q <= PW'(nm_q) * PW'(nm_q);
      scf_pkg::OP_SUB_N:  num_q  <= nd_full[RADICAND_BITS-1:0];
      scf_pkg::OP_DIV_D: begin
        if (div_sts.done) begin
          d_q <= div_quo[VW-1:0];
          m_q <= nm_q;
        end
      end
      scf_pkg::OP_DIV_A: begin
        if (div_sts.done) a_q <= div_quo[VW-1:0];
      end
      default: begin
      end
    endcase
  end

  scf_div #(
    .NW(RADICAND_BITS),
    .DW(VW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (d_q),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  assign in_ready_o  = (uw.op == scf_pkg::OP_IDLE);
  assign out_valid_o = out_valid_q;
  assign term_o      = term_q;
  assign last_o      = last_q;
  assign truncated_o = trunc_q;

  `SCF_ASSERT(a_trunc_on_last, !(out_valid_o && truncated_o) || last_o, "truncated without last")
  `SCF_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `SCF_ASSERT(a_term_cap, term_cnt_q <= TCW'(MAX_TERMS - 1), "term count past cap")
  `SCF_ASSERT(a_div_step, !div_sts.done || div_op, "divider done outside a divide step")
  `SCF_ASSERT(a_div_busy, !div_sts.busy || div_op, "divider busy outside a divide step")

endmodule

### tb/sqrt_continued_fraction_test.sv
// Self-checking regression for the square root continued fraction block.
module sqrt_continued_fraction_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERM_W       = scf_pkg::TERM_W;
  localparam int RAD_W        = 10;
  localparam int TERM_CAP     = 64;
  localparam int RANDOM_ITEMS = 135;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_INDEX  = 100;
  localparam int SETTLE       = 100;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic              last;
    logic              truncated;
  } term_rec_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [RAD_W-1:0]  radicand_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [TERM_W-1:0] term_o;
  logic              last_o;
  logic              truncated_o;

  logic [RAD_W-1:0] radicand_q[$];
  term_rec_t        term_q[$];
  int               total_items = 0;
  int               n_sent      = 0;
  int               n_terms     = 0;
  int               n_errors    = 0;
  int unsigned      cycles      = 0;

  sqrt_continued_fraction #(
    .RADICAND_BITS(RAD_W),
    .MAX_TERMS    (TERM_CAP)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .radicand_i,
    .out_valid_o,
    .out_ready_i,
    .term_o,
    .last_o,
    .truncated_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Append one expected term.
  function automatic void queue_term(input int unsigned t, input bit lst, input bit trn);
    term_rec_t rec;
    rec.term      = TERM_W'(t);
    rec.last      = lst;
    rec.truncated = trn;
    term_q.insert(term_q.size(), rec);
  endfunction

  // Expand sqrt(n) into the terms the block should emit.
  task automatic expand_root(input logic [RAD_W-1:0] n);
    int unsigned root, m, d, a, nm, nd, cnt;
    bit          done;
    root = 0;
    while ((root + 1) * (root + 1) <= n) root++;
    if (root * root == n) begin
      queue_term(root, 1'b1, 1'b0);
      return;
    end
    m    = 0;
    d    = 1;
    a    = root;
    cnt  = 0;
    done = 1'b0;
    while (!done) begin
      if (cnt > 0 && a == 2 * root) begin
        queue_term(a, 1'b1, 1'b0);
        done = 1'b1;
      end else if (cnt + 1 >= TERM_CAP) begin
        queue_term(a, 1'b1, 1'b1);
        done = 1'b1;
      end else begin
        nm = d * a - m;
        nd = n - nm * nm;
        if (d == 0 || nd == 0) begin
          // guard only: a non-square radicand never gets here
          queue_term(a, 1'b1, 1'b1);
          done = 1'b1;
        end else begin
          queue_term(a, 1'b0, 1'b0);
          cnt++;
          m = nm;
          d = nd / d;
          a = (root + m) / d;
        end
      end
    end
  endtask

  // Request driver: offer queued radicands, idling by phase.
  always @(posedge clk_i) begin
    int  idle_pct;
    bit  fire;
    bit  hold_back;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        expand_root(radicand_i);
        n_sent++;
      end
      if (!in_valid_i || fire) begin
        if (n_sent < total_items / 3) idle_pct = 34;
        else if (n_sent < 2 * total_items / 3) idle_pct = 61;
        else idle_pct = 0;
        // pause once until the block has drained every term
        hold_back = (n_sent == DRAIN_INDEX) && (term_q.size() != 0);
        if (radicand_q.size() != 0 && !hold_back && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          radicand_i <= radicand_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Term monitor: check each accepted term, then pick the next ready.
  always @(posedge clk_i) begin
    int        idle_pct;
    int        hold_left;
    bit        hold_done;
    term_rec_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_terms++;
        if (term_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected term %0d last %0b truncated %0b", term_o, last_o,
                     truncated_o);
        end else begin
          want = term_q.pop_front();
          if (term_o !== want.term || last_o !== want.last ||
              truncated_o !== want.truncated) begin
            n_errors++;
            if (n_errors <= 10)
              $display("term mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
                       want.term, want.last, want.truncated,
                       term_o, last_o, truncated_o);
          end
        end
      end
      if (!hold_done && n_terms >= 60) begin
        // stall the output long enough for the input to back up
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (n_sent < total_items / 3) idle_pct = 61;
      else if (n_sent < 2 * total_items / 3) idle_pct = 34;
      else idle_pct = 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sqrt_continued_fraction regression: fail");
      $finish;
    end
  end

  initial begin
    int               k;
    logic [RAD_W-1:0] directed[];
    directed = '{
      10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd1023, 10'd1022, 10'd961,
      10'd960, 10'd962, 10'd512, 10'd511, 10'd13, 10'd94, 10'd139, 10'd151,
      10'd166, 10'd421, 10'd661, 10'd919, 10'd991, 10'd1021, 10'd682, 10'd900
    };
    foreach (directed[i]) radicand_q.insert(radicand_q.size(), directed[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(31);
        radicand_q.insert(radicand_q.size(), RAD_W'(k * k));
      end else begin
        radicand_q.insert(radicand_q.size(), RAD_W'($urandom_range(1023)));
      end
    end
    total_items = radicand_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < total_items) @(negedge clk_i);
    while (term_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (term_q.size() != 0) n_errors++;

    if (n_errors == 0) begin
      $display("sqrt_continued_fraction regression: pass");
    end else begin
      $display("sqrt_continued_fraction regression: fail");
    end
    $finish;
  end

endmodule
